/* hdl/ltc_pkg.sv */
// shared types and constants of the lru translation cache
`timescale 1ns / 1ps

package ltc_pkg;

    localparam int LTC_ENTRIES = 64;
    localparam int LTC_CFG_IW  = 2;
    localparam int LTC_CFG_DW  = 32;

    localparam logic [LTC_CFG_IW-1:0] CFG_CAPACITY     = 2'd0;
    localparam logic [LTC_CFG_IW-1:0] CFG_STREAM_LIMIT = 2'd1;
    localparam logic [LTC_CFG_IW-1:0] CFG_PASID_LIMIT  = 2'd2;

    localparam logic [6:0]  CAPACITY_RESET     = 7'd64;
    localparam logic [31:0] STREAM_LIMIT_RESET = 32'hFFFF_FFFF;
    localparam logic [19:0] PASID_LIMIT_RESET  = 20'hF_FFFF;
    localparam logic [31:0] COUNTER_MAX        = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_LOOKUP     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_INV_KEY    = 3'd2,
        OP_INV_STREAM = 3'd3,
        OP_INV_SP     = 3'd4,
        OP_INV_SEC    = 3'd5,
        OP_INV_ALL    = 3'd6,
        OP_RST_STATS  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_STREAM = 2'd1,
        ST_BAD_PASID  = 2'd2,
        ST_MISS       = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC,
        S_ALLOC,
        S_DROP,
        S_READ,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op         opcode;
        logic [31:0] stream_id;
        logic [19:0] pasid;
        logic [47:0] iova;
        logic [1:0]  security_state;
        logic [51:0] new_physical_address;
        logic [2:0]  new_permissions;
        logic [63:0] new_timestamp;
    } t_in_item;

    typedef struct packed {
        logic        hit;
        t_status     status;
        logic [51:0] physical_address;
        logic [2:0]  permissions;
        logic [63:0] entry_timestamp;
        logic [6:0]  entry_count;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_out_item;

    typedef struct packed {
        logic [51:0] pa;
        logic [2:0]  perm;
        logic [63:0] ts;
    } t_entry_data;

    typedef struct packed {
        logic [6:0]  capacity;
        logic [31:0] stream_limit;
        logic [19:0] pasid_limit;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic match;
        logic touch;
        logic mem_rd;
        logic mem_wr;
        logic evict;
        logic alloc;
        logic drop;
        logic clear_all;
        logic finish;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic any_match;
        logic limit_err;
        logic full;
        logic need_trim;
    } t_stat;

endpackage

/* hdl/ltc_ctrl.sv */
// controller state machine of the lru translation cache
`timescale 1ns / 1ps

module ltc_ctrl
    import ltc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  logic  i_cfg_we,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = !i_cfg_we && !i_stat.need_trim;
                if (i_stat.need_trim) begin
                    o_cmd.evict = 1'b1;
                end else if (o_in_ready && i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MATCH;
                end
            end
            S_MATCH: begin
                o_cmd.match = 1'b1;
                n_state     = S_EXEC;
            end
            S_EXEC: begin
                unique case (i_stat.op)
                    OP_LOOKUP: begin
                        if (i_stat.limit_err || !i_stat.any_match) begin
                            o_cmd.finish = 1'b1;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.touch  = 1'b1;
                            o_cmd.mem_rd = 1'b1;
                            n_state      = S_READ;
                        end
                    end
                    OP_INSERT: begin
                        if (i_stat.any_match) begin
                            o_cmd.touch  = 1'b1;
                            o_cmd.mem_wr = 1'b1;
                            o_cmd.finish = 1'b1;
                            n_state      = S_DONE;
                        end else begin
                            o_cmd.evict = i_stat.full;
                            n_state     = S_ALLOC;
                        end
                    end
                    OP_INV_KEY, OP_INV_STREAM, OP_INV_SP, OP_INV_SEC: begin
                        n_state = S_DROP;
                    end
                    OP_INV_ALL: begin
                        o_cmd.clear_all = 1'b1;
                        o_cmd.finish    = 1'b1;
                        n_state         = S_DONE;
                    end
                    OP_RST_STATS: begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_ALLOC: begin
                o_cmd.alloc  = 1'b1;
                o_cmd.mem_wr = 1'b1;
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DROP: begin
                if (i_stat.any_match) begin
                    o_cmd.drop = 1'b1;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_READ: begin
                o_cmd.finish = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* hdl/ltc_dp.sv */
// datapath of the lru translation cache: key cells, recency ranks, data memory, counters
`timescale 1ns / 1ps

module ltc_dp
    import ltc_pkg::*;
#(
    parameter int ENTRIES = LTC_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_in_item  i_in_item,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output t_out_item o_out_item
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = (CW > 7) ? CW : 7;

    t_in_item    r_item;
    logic [ENTRIES-1:0] r_match;
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0] r_rank [ENTRIES];
    logic [31:0] r_key_stream [ENTRIES];
    logic [19:0] r_key_pasid [ENTRIES];
    logic [47:0] r_key_addr [ENTRIES];
    logic [1:0]  r_key_sec [ENTRIES];
    t_entry_data r_mem [ENTRIES];
    t_entry_data r_rd;
    logic [CW-1:0] r_count, n_count;
    logic [31:0] r_hit_cnt;
    logic [31:0] r_miss_cnt;
    logic        r_res_hit;
    t_status     r_res_status;

    logic [ENTRIES-1:0] w_match;
    logic [ENTRIES-1:0] w_oldest;
    logic [IW-1:0] w_sel;
    logic [IW-1:0] w_victim;
    logic [IW-1:0] w_free;
    logic [IW-1:0] w_sel_rank;
    logic [IW-1:0] w_wr_addr;
    logic [EW-1:0] w_count_x;
    logic [EW-1:0] w_cap_x;
    logic [EW-1:0] w_eff_cap;
    logic          w_hit;
    t_status       w_status;

    function automatic logic [IW-1:0] first_set(input logic [ENTRIES-1:0] v);
        logic [IW-1:0] idx;
        idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = IW'(i);
            end
        end
        return idx;
    endfunction

    always_comb begin
        for (int j = 0; j < ENTRIES; j++) begin
            unique case (r_item.opcode)
                OP_LOOKUP, OP_INSERT, OP_INV_KEY: begin
                    w_match[j] = r_valid[j] && r_key_stream[j] == r_item.stream_id
                        && r_key_pasid[j] == r_item.pasid && r_key_addr[j] == r_item.iova
                        && r_key_sec[j] == r_item.security_state;
                end
                OP_INV_STREAM: begin
                    w_match[j] = r_valid[j] && r_key_stream[j] == r_item.stream_id;
                end
                OP_INV_SP: begin
                    w_match[j] = r_valid[j] && r_key_stream[j] == r_item.stream_id
                        && r_key_pasid[j] == r_item.pasid;
                end
                OP_INV_SEC: begin
                    w_match[j] = r_valid[j] && r_key_sec[j] == r_item.security_state;
                end
                default: begin
                    w_match[j] = 1'b0;
                end
            endcase
            w_oldest[j] = r_valid[j] && r_rank[j] == IW'(r_count - CW'(1));
        end
    end

    assign w_sel      = first_set(r_match);
    assign w_victim   = first_set(w_oldest);
    assign w_free     = first_set(~r_valid);
    assign w_sel_rank = r_rank[w_sel];
    assign w_wr_addr  = i_cmd.alloc ? w_free : w_sel;

    assign w_count_x = EW'(r_count);
    assign w_cap_x   = EW'(i_cfg.capacity);
    assign w_eff_cap = (w_cap_x == '0) ? EW'(1)
                     : ((w_cap_x > EW'(ENTRIES)) ? EW'(ENTRIES) : w_cap_x);

    always_comb begin
        priority if (i_cfg.stream_limit < r_item.stream_id) begin
            w_status = ST_BAD_STREAM;
        end else if (i_cfg.pasid_limit < r_item.pasid) begin
            w_status = ST_BAD_PASID;
        end else if (!(|r_match)) begin
            w_status = ST_MISS;
        end else begin
            w_status = ST_OK;
        end
    end
    assign w_hit = (w_status == ST_OK);

    assign o_stat.op        = r_item.opcode;
    assign o_stat.any_match = |r_match;
    assign o_stat.limit_err = (w_status == ST_BAD_STREAM) || (w_status == ST_BAD_PASID);
    assign o_stat.full      = w_count_x >= w_eff_cap;
    assign o_stat.need_trim = w_count_x > w_eff_cap;

    always_comb begin
        n_count = r_count;
        priority if (i_cmd.clear_all) begin
            n_count = '0;
        end else if (i_cmd.evict || i_cmd.drop) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.alloc) begin
            n_count = r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.match) begin
            r_match <= w_match;
        end else if (i_cmd.drop) begin
            r_match[w_sel] <= 1'b0;
        end
        if (i_cmd.alloc) begin
            r_key_stream[w_free] <= r_item.stream_id;
            r_key_pasid[w_free]  <= r_item.pasid;
            r_key_addr[w_free]   <= r_item.iova;
            r_key_sec[w_free]    <= r_item.security_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr) begin
            r_mem[w_wr_addr] <= '{pa: r_item.new_physical_address,
                                  perm: r_item.new_permissions,
                                  ts: r_item.new_timestamp};
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_mem[w_sel];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            for (int j = 0; j < ENTRIES; j++) begin
                r_rank[j] <= '0;
            end
        end else begin
            r_count <= n_count;
            for (int j = 0; j < ENTRIES; j++) begin
                priority if (i_cmd.clear_all) begin
                    r_valid[j] <= 1'b0;
                end else if (i_cmd.evict) begin
                    if (IW'(j) == w_victim) begin
                        r_valid[j] <= 1'b0;
                    end
                end else if (i_cmd.drop) begin
                    if (IW'(j) == w_sel) begin
                        r_valid[j] <= 1'b0;
                    end else if (r_valid[j] && r_rank[j] > w_sel_rank) begin
                        r_rank[j] <= r_rank[j] - IW'(1);
                    end
                end else if (i_cmd.touch) begin
                    if (IW'(j) == w_sel) begin
                        r_rank[j] <= '0;
                    end else if (r_valid[j] && r_rank[j] < w_sel_rank) begin
                        r_rank[j] <= r_rank[j] + IW'(1);
                    end
                end else if (i_cmd.alloc) begin
                    if (IW'(j) == w_free) begin
                        r_valid[j] <= 1'b1;
                        r_rank[j]  <= '0;
                    end else if (r_valid[j]) begin
                        r_rank[j] <= r_rank[j] + IW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt    <= '0;
            r_miss_cnt   <= '0;
            r_res_hit    <= 1'b0;
            r_res_status <= ST_OK;
        end else if (i_cmd.finish) begin
            r_res_hit    <= 1'b0;
            r_res_status <= ST_OK;
            if (r_item.opcode == OP_LOOKUP) begin
                r_res_hit    <= w_hit;
                r_res_status <= w_status;
                if (w_hit) begin
                    if (r_hit_cnt != COUNTER_MAX) begin
                        r_hit_cnt <= r_hit_cnt + 32'd1;
                    end
                end else if (r_miss_cnt != COUNTER_MAX) begin
                    r_miss_cnt <= r_miss_cnt + 32'd1;
                end
            end else if (r_item.opcode == OP_RST_STATS) begin
                r_hit_cnt  <= '0;
                r_miss_cnt <= '0;
            end
        end
    end

    assign o_out_item.hit              = r_res_hit;
    assign o_out_item.status           = r_res_status;
    assign o_out_item.physical_address = r_res_hit ? r_rd.pa : '0;
    assign o_out_item.permissions      = r_res_hit ? r_rd.perm : '0;
    assign o_out_item.entry_timestamp  = r_res_hit ? r_rd.ts : '0;
    assign o_out_item.entry_count      = 7'(r_count);
    assign o_out_item.hit_total        = r_hit_cnt;
    assign o_out_item.miss_total       = r_miss_cnt;

endmodule

/* hdl/lru_translation_cache.sv */
// top level of the lru translation cache: configuration registers and unit wiring
`timescale 1ns / 1ps
// fully associative translation cache with least recently used replacement
// input channel: i_in_valid / o_in_ready carry one item (opcode, key, insert data)
// output channel: o_out_valid / i_out_ready carry exactly one result item per input item
// configuration: i_cfg_we writes i_cfg_data into the register at i_cfg_index
// (0 capacity, 1 stream limit, 2 pasid limit); other indexes are ignored
// one item is in flight at a time; after acceptance each item passes the match and
// execute states; lookup miss or error, insert hit, invalidate all and reset stats then
// give the result, lookup hit adds a read state, insert miss an allocate state, and
// invalidate by key, stream, stream and pasid, security a drop state for each dropped entry
// a new item is taken only once the controller is idle again after the result is consumed;
// a lookup hit does the match, then the rank update with the data memory read
// lowering capacity evicts one entry per cycle while idle, with o_in_ready low until done
// reset empties the cache, clears both counters and restores register defaults
// a stalled result is held on o_out_item until i_out_ready is seen

module lru_translation_cache
    import ltc_pkg::*;
#(
    parameter int ENTRIES = LTC_ENTRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [LTC_CFG_IW-1:0] i_cfg_index,
    input  logic [LTC_CFG_DW-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_cmd  w_cmd;
    t_stat w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.capacity     <= CAPACITY_RESET;
            r_cfg.stream_limit <= STREAM_LIMIT_RESET;
            r_cfg.pasid_limit  <= PASID_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CAPACITY:     r_cfg.capacity     <= i_cfg_data[6:0];
                CFG_STREAM_LIMIT: r_cfg.stream_limit <= i_cfg_data[31:0];
                CFG_PASID_LIMIT:  r_cfg.pasid_limit  <= i_cfg_data[19:0];
                default: begin
                end
            endcase
        end
    end

    ltc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    ltc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_item  (i_in_item),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_item (o_out_item)
    );

endmodule

/* verif/tb_lru_translation_cache.sv */
// testbench of the lru translation cache: directed and random traffic checked against a predictor
`timescale 1ns / 1ps

module tb_lru_translation_cache;
    import ltc_pkg::*;

    localparam int SLOTS      = LTC_ENTRIES;
    localparam int SETTLE     = 90;
    localparam int CYCLE_CAP  = 400000;
    localparam int POOL_SIZE  = 16;

    class ltc_scoreboard;
        bit          vld  [SLOTS];
        logic [31:0] k_sid[SLOTS];
        logic [19:0] k_pas[SLOTS];
        logic [47:0] k_va [SLOTS];
        logic [1:0]  k_sec[SLOTS];
        logic [51:0] d_pa [SLOTS];
        logic [2:0]  d_pm [SLOTS];
        logic [63:0] d_ts [SLOTS];
        int          rank [SLOTS];
        logic [31:0] hits, misses;
        int          cap_eff;
        logic [31:0] stream_lim;
        logic [19:0] pasid_lim;
        t_out_item   awaited[$];
        int          errors, checked, hit_seen, evicted;

        function new();
            foreach (vld[i]) begin
                vld[i] = 0;
                rank[i] = 0;
            end
            hits = '0;
            misses = '0;
            cap_eff = SLOTS;
            stream_lim = STREAM_LIMIT_RESET;
            pasid_lim = PASID_LIMIT_RESET;
            errors = 0;
            checked = 0;
            hit_seen = 0;
            evicted = 0;
        endfunction

        function int occupancy();
            int n;
            n = 0;
            foreach (vld[i]) if (vld[i]) n++;
            return n;
        endfunction

        function void drop(int s);
            int r;
            r = rank[s];
            vld[s] = 0;
            foreach (vld[j]) if (vld[j] && rank[j] > r) rank[j]--;
        endfunction

        function void touch(int s);
            int r;
            r = rank[s];
            foreach (vld[j]) if (j != s && vld[j] && rank[j] < r) rank[j]++;
            rank[s] = 0;
        endfunction

        function void evict_lru();
            int n;
            n = occupancy();
            foreach (vld[i]) begin
                if (n > 0 && vld[i] && rank[i] == n - 1) begin
                    drop(i);
                    evicted++;
                    return;
                end
            end
        endfunction

        function int find(t_in_item it);
            foreach (vld[i])
                if (vld[i] && k_sid[i] == it.stream_id && k_pas[i] == it.pasid &&
                    k_va[i] == it.iova && k_sec[i] == it.security_state)
                    return i;
            return -1;
        endfunction

        function void set_reg(logic [LTC_CFG_IW-1:0] idx, logic [LTC_CFG_DW-1:0] data);
            int c;
            case (idx)
                CFG_CAPACITY: begin
                    c = data[6:0];
                    cap_eff = (c < 1) ? 1 : (c > SLOTS) ? SLOTS : c;
                    while (occupancy() > cap_eff) evict_lru();
                end
                CFG_STREAM_LIMIT: stream_lim = data;
                CFG_PASID_LIMIT:  pasid_lim = data[19:0];
                default: ;
            endcase
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            int s;
            r = '0;
            r.status = ST_OK;
            case (it.opcode)
                OP_LOOKUP: begin
                    if (it.stream_id > stream_lim) r.status = ST_BAD_STREAM;
                    else if (it.pasid > pasid_lim) r.status = ST_BAD_PASID;
                    else begin
                        s = find(it);
                        if (s < 0) r.status = ST_MISS;
                        else begin
                            touch(s);
                            r.hit = 1'b1;
                            r.physical_address = d_pa[s];
                            r.permissions = d_pm[s];
                            r.entry_timestamp = d_ts[s];
                        end
                    end
                    if (r.hit) begin
                        if (hits != COUNTER_MAX) hits++;
                    end else begin
                        if (misses != COUNTER_MAX) misses++;
                    end
                end
                OP_INSERT: begin
                    s = find(it);
                    if (s < 0) begin
                        if (occupancy() >= cap_eff) evict_lru();
                        foreach (vld[i]) if (s < 0 && !vld[i]) s = i;
                        foreach (vld[j]) if (vld[j]) rank[j]++;
                        vld[s] = 1;
                        rank[s] = 0;
                        k_sid[s] = it.stream_id;
                        k_pas[s] = it.pasid;
                        k_va[s] = it.iova;
                        k_sec[s] = it.security_state;
                    end else begin
                        touch(s);
                    end
                    d_pa[s] = it.new_physical_address;
                    d_pm[s] = it.new_permissions;
                    d_ts[s] = it.new_timestamp;
                end
                OP_INV_KEY: begin
                    s = find(it);
                    if (s >= 0) drop(s);
                end
                OP_INV_STREAM:
                    foreach (vld[i]) if (vld[i] && k_sid[i] == it.stream_id) drop(i);
                OP_INV_SP:
                    foreach (vld[i])
                        if (vld[i] && k_sid[i] == it.stream_id && k_pas[i] == it.pasid)
                            drop(i);
                OP_INV_SEC:
                    foreach (vld[i]) if (vld[i] && k_sec[i] == it.security_state) drop(i);
                OP_INV_ALL:
                    foreach (vld[i]) begin
                        vld[i] = 0;
                        rank[i] = 0;
                    end
                default: begin
                    hits = '0;
                    misses = '0;
                end
            endcase
            r.entry_count = 7'(occupancy());
            r.hit_total = hits;
            r.miss_total = misses;
            awaited = {awaited, r};
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 30)
                $display("mismatch at result %0d, %s: got %h, want %h",
                         checked, field, got, want);
        endtask

        task check(t_out_item got);
            t_out_item w;
            checked++;
            if (awaited.size() == 0) begin
                report("unexpected result", got.entry_count, 0);
                return;
            end
            w = awaited.pop_front();
            if (w.hit) hit_seen++;
            if (got.hit !== w.hit) report("hit", got.hit, w.hit);
            if (got.status !== w.status) report("status", got.status, w.status);
            if (got.physical_address !== w.physical_address)
                report("physical_address", got.physical_address, w.physical_address);
            if (got.permissions !== w.permissions)
                report("permissions", got.permissions, w.permissions);
            if (got.entry_timestamp !== w.entry_timestamp)
                report("entry_timestamp", got.entry_timestamp, w.entry_timestamp);
            if (got.entry_count !== w.entry_count)
                report("entry_count", got.entry_count, w.entry_count);
            if (got.hit_total !== w.hit_total)
                report("hit_total", got.hit_total, w.hit_total);
            if (got.miss_total !== w.miss_total)
                report("miss_total", got.miss_total, w.miss_total);
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;
    logic                  i_cfg_we = 1'b0;
    logic [LTC_CFG_IW-1:0] i_cfg_index = '0;
    logic [LTC_CFG_DW-1:0] i_cfg_data = '0;

    ltc_scoreboard cache_sb = new();
    t_in_item      key_pool[POOL_SIZE];
    int            cycles = 0;
    int            burst_left = 0;
    int            sent = 0;

    lru_translation_cache i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
        end
        if (i_rst_n && o_out_valid && i_out_ready) cache_sb.check(o_out_item);
    end

    // receiver stall pattern cycles through always ready, random and sparse
    always @(negedge i_clk) begin
        case ((cycles / 300) % 3)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 1) == 1);
            default: i_out_ready <= (cycles % 5 == 0);
        endcase
    end

    task send_item(t_in_item it);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        cache_sb.note_item(it);
        burst_left--;
        sent++;
    endtask

    task drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (cache_sb.awaited.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task cfg_write(logic [LTC_CFG_IW-1:0] idx, logic [LTC_CFG_DW-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        cache_sb.set_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item make_item(t_op op, int key_sel);
        t_in_item it;
        it = key_sel < 0 ? t_in_item'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom})
                         : key_pool[key_sel];
        it.opcode = op;
        it.new_physical_address = 52'({$urandom, $urandom});
        it.new_permissions = 3'($urandom_range(0, 7));
        it.new_timestamp = {$urandom, $urandom};
        return it;
    endfunction

    function automatic t_in_item random_item();
        int pick, sel;
        t_op op;
        pick = $urandom_range(0, 99);
        if (pick < 45) op = OP_LOOKUP;
        else if (pick < 80) op = OP_INSERT;
        else if (pick < 86) op = OP_INV_KEY;
        else if (pick < 89) op = OP_INV_STREAM;
        else if (pick < 92) op = OP_INV_SP;
        else if (pick < 95) op = OP_INV_SEC;
        else if (pick < 97) op = OP_INV_ALL;
        else op = OP_RST_STATS;
        sel = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, POOL_SIZE - 1);
        return make_item(op, sel);
    endfunction

    task random_phase(int n);
        repeat (n) send_item(random_item());
        drain();
    endtask

    initial begin
        logic [31:0] sids[4];
        logic [19:0] pids[4];
        sids = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0001, 32'hFFFF_FFFF};
        pids = '{20'h0, 20'h7FFFF, 20'h80001, 20'hFFFFF};
        foreach (key_pool[i]) begin
            key_pool[i] = '0;
            key_pool[i].stream_id = sids[i % 4];
            key_pool[i].pasid = pids[(i / 4) % 4];
            key_pool[i].iova = (i == 0) ? 48'h0 : (i == 1) ? {48{1'b1}}
                             : 48'({$urandom, $urandom});
            key_pool[i].security_state = 2'($urandom_range(0, 3));
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty lookup, fills, hits, reinsert, each invalidate, stats
        send_item(make_item(OP_LOOKUP, 0));
        for (int i = 0; i < 6; i++) send_item(make_item(OP_INSERT, i));
        send_item(make_item(OP_LOOKUP, 1));
        send_item(make_item(OP_INSERT, 1));
        send_item(make_item(OP_LOOKUP, 1));
        send_item(make_item(OP_LOOKUP, 0));
        send_item(make_item(OP_INV_KEY, 0));
        send_item(make_item(OP_LOOKUP, 0));
        send_item(make_item(OP_INV_STREAM, 1));
        send_item(make_item(OP_INV_SP, 2));
        send_item(make_item(OP_INV_SEC, 3));
        send_item(make_item(OP_RST_STATS, 4));
        send_item(make_item(OP_INV_ALL, 4));
        send_item(make_item(OP_LOOKUP, -1));
        drain();

        // unknown register index must be ignored
        cfg_write(2'd3, '1);
        cfg_write(CFG_CAPACITY, 32'd4);
        random_phase(100);
        cfg_write(CFG_CAPACITY, 32'd0);
        random_phase(60);
        cfg_write(CFG_CAPACITY, 32'd127);
        cfg_write(CFG_STREAM_LIMIT, 32'h8000_0000);
        cfg_write(CFG_PASID_LIMIT, 32'h80000);
        random_phase(120);
        cfg_write(CFG_STREAM_LIMIT, 32'd0);
        cfg_write(CFG_PASID_LIMIT, 32'd0);
        random_phase(60);
        cfg_write(CFG_STREAM_LIMIT, 32'hFFFF_FFFF);
        cfg_write(CFG_PASID_LIMIT, 32'hF_FFFF);
        cfg_write(CFG_CAPACITY, 32'd64);
        random_phase(120);
        // lowering capacity evicts the oldest entries
        cfg_write(CFG_CAPACITY, 32'd3);
        random_phase(80);
        cfg_write(CFG_CAPACITY, 32'd1);
        random_phase(60);

        if (cache_sb.awaited.size() != 0)
            cache_sb.report("results never arrived", cache_sb.awaited.size(), 0);
        $display("%0d items sent, %0d results checked, %0d hits, %0d evictions predicted",
                 sent, cache_sb.checked, cache_sb.hit_seen, cache_sb.evicted);
        $display("capacity 1..64 and clamped writes, limits at both extremes, all opcodes");
        if (cache_sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/ltc_pkg.sv
hdl/ltc_ctrl.sv
hdl/ltc_dp.sv
hdl/lru_translation_cache.sv
verif/tb_lru_translation_cache.sv
